FILE: rtl/tpc_pkg.sv
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared widths and the command and status bundles of the twin prime counter.
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int VALUE_BITS = 32;
  localparam int VAL_W      = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int DIV_W      = VAL_W / 2 + 1;
  localparam int SQ_W       = 2 * DIV_W;
  localparam int BIT_W      = $clog2(VAL_W);
  localparam int COUNT_W    = 32;

  typedef struct packed {
    logic ready;
    logic div_start;
    logic div_step;
    logic next_div;
    logic finish;
    logic prime;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic below_two;
    logic is_two;
    logic even;
    logic sq_gt;
    logic last_bit;
    logic rem_zero;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/tpc_in_if.sv
// ----------------------------------------------------------------------------
// tpc_in_if
// Candidate channel: one word is a number to test and a restart flag.
// ----------------------------------------------------------------------------
interface tpc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] candidate;
  logic        restart;

  modport source (output valid, output candidate, output restart, input ready);
  modport sink   (input valid, input candidate, input restart, output ready);
endinterface

FILE: rtl/tpc_out_if.sv
// ----------------------------------------------------------------------------
// tpc_out_if
// Result channel: prime flag, twin flag and running pair count per word.
// ----------------------------------------------------------------------------
interface tpc_out_if;
  logic        valid;
  logic        ready;
  logic        is_prime;
  logic        twin_found;
  logic [31:0] pair_total;

  modport source (output valid, output is_prime, output twin_found, output pair_total,
                  input ready);
  modport sink   (input valid, input is_prime, input twin_found, input pair_total,
                  output ready);
endinterface

FILE: rtl/tpc_ctrl.sv
// ----------------------------------------------------------------------------
// tpc_ctrl
// Sequencer for the trial division: classify, square check, bit-serial
// remainder, divisor advance, result hand-off.
// ----------------------------------------------------------------------------
module tpc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  tpc_pkg::stat_t stat,
  output tpc_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    IDLE,
    CLASSIFY,
    CHECK,
    DIVIDE,
    TEST,
    HOLD
  } state_t;

  state_t state;
  logic   verdict;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      verdict <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (stat.in_valid) state <= CLASSIFY;
        end
        CLASSIFY: begin
          if (stat.below_two) begin
            verdict <= 1'b0;
            state   <= HOLD;
          end else if (stat.is_two) begin
            verdict <= 1'b1;
            state   <= HOLD;
          end else if (stat.even) begin
            verdict <= 1'b0;
            state   <= HOLD;
          end else begin
            state <= CHECK;
          end
        end
        CHECK: begin
          if (stat.sq_gt) begin
            verdict <= 1'b1;
            state   <= HOLD;
          end else begin
            state <= DIVIDE;
          end
        end
        DIVIDE: begin
          if (stat.last_bit) state <= TEST;
        end
        TEST: begin
          if (stat.rem_zero) begin
            verdict <= 1'b0;
            state   <= HOLD;
          end else begin
            state <= CHECK;
          end
        end
        HOLD: begin
          if (stat.out_free) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.ready     = (state == IDLE);
    cmd.div_start = (state == CHECK) && !stat.sq_gt;
    cmd.div_step  = (state == DIVIDE);
    cmd.next_div  = (state == TEST) && !stat.rem_zero;
    cmd.finish    = (state == HOLD) && stat.out_free;
    cmd.prime     = verdict;
  end

endmodule

FILE: rtl/tpc_dp.sv
// ----------------------------------------------------------------------------
// tpc_dp
// Datapath: candidate and divisor registers, running square, restoring
// remainder one bit per cycle, twin flag and saturating pair count.
// ----------------------------------------------------------------------------
module tpc_dp (
  input  logic           clk,
  input  logic           rst,
  input  tpc_pkg::cmd_t  cmd,
  output tpc_pkg::stat_t stat,
  tpc_in_if.sink         items,
  tpc_out_if.source      results
);

  logic [tpc_pkg::VAL_W-1:0]   value;
  logic                        restart_q;
  logic [tpc_pkg::DIV_W-1:0]   divisor;
  logic [tpc_pkg::SQ_W-1:0]    square;
  logic [tpc_pkg::DIV_W-1:0]   rem;
  logic [tpc_pkg::BIT_W-1:0]   bit_idx;
  logic [tpc_pkg::DIV_W:0]     shifted;
  logic [tpc_pkg::DIV_W:0]     diff;
  logic                        out_valid;
  logic                        out_prime;
  logic                        out_twin;
  logic [tpc_pkg::COUNT_W-1:0] out_total;
  logic                        prev_prime;
  logic [tpc_pkg::COUNT_W-1:0] pair_count;
  logic                        prev_eff;
  logic [tpc_pkg::COUNT_W-1:0] count_eff;
  logic                        twin;
  logic [tpc_pkg::COUNT_W-1:0] count_next;
  logic                        load;

  assign load        = cmd.ready && items.valid;
  assign items.ready = cmd.ready;

  assign shifted = {rem, value[bit_idx]};
  assign diff    = shifted - {1'b0, divisor};

  assign prev_eff   = restart_q ? 1'b0 : prev_prime;
  assign count_eff  = restart_q ? '0 : pair_count;
  assign twin       = prev_eff && cmd.prime;
  assign count_next = (twin && (count_eff != '1)) ? count_eff + 1'b1 : count_eff;

  always_comb begin
    stat           = '0;
    stat.in_valid  = items.valid;
    stat.below_two = (value < tpc_pkg::VAL_W'(2));
    stat.is_two    = (value == tpc_pkg::VAL_W'(2));
    stat.even      = !value[0];
    stat.sq_gt     = (square > tpc_pkg::SQ_W'(value));
    stat.last_bit  = (bit_idx == '0);
    stat.rem_zero  = (rem == '0);
    stat.out_free  = !out_valid || results.ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      prev_prime <= 1'b0;
      pair_count <= '0;
      divisor    <= tpc_pkg::DIV_W'(3);
    end else begin
      if (cmd.finish) begin
        out_valid  <= 1'b1;
        prev_prime <= cmd.prime;
        pair_count <= count_next;
        divisor    <= tpc_pkg::DIV_W'(3);
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        divisor <= tpc_pkg::DIV_W'(3);
      end else if (cmd.next_div) begin
        divisor <= divisor + tpc_pkg::DIV_W'(2);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      value     <= items.candidate[tpc_pkg::VAL_W-1:0];
      restart_q <= items.restart;
      square    <= tpc_pkg::SQ_W'(9);
    end else if (cmd.next_div) begin
      square <= square + tpc_pkg::SQ_W'({divisor, 2'b00}) + tpc_pkg::SQ_W'(4);
    end
    if (cmd.div_start) begin
      rem     <= '0;
      bit_idx <= tpc_pkg::BIT_W'(tpc_pkg::VAL_W - 1);
    end else if (cmd.div_step) begin
      rem     <= diff[tpc_pkg::DIV_W] ? shifted[tpc_pkg::DIV_W-1:0]
                                      : diff[tpc_pkg::DIV_W-1:0];
      bit_idx <= bit_idx - 1'b1;
    end
    if (cmd.finish) begin
      out_prime <= cmd.prime;
      out_twin  <= twin;
      out_total <= count_next;
    end
  end

  assign results.valid      = out_valid;
  assign results.is_prime   = out_prime;
  assign results.twin_found = out_twin;
  assign results.pair_total = out_total;

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || results.ready))
    else $error("result written over a word not yet taken");

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |=> (rem < divisor))
    else $error("remainder not below divisor");

  a_twin_prime: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.twin_found) |-> results.is_prime)
    else $error("twin flagged on a composite");

endmodule

FILE: rtl/twin_prime_counter_unit.sv
// ----------------------------------------------------------------------------
// twin_prime_counter_unit
// Trial-division primality test with twin-pair flag and saturating count.
// ----------------------------------------------------------------------------
// One word in, one word out. Values below two and even values other than two
// are settled in the classify step, without any division. An odd value n is
// divided by the odd divisors from 3 up while their square is at most n, so
// up to about sqrt(n) / 2 divisors are tried: each divisor needs one square
// check, a restoring remainder at one bit per cycle, and one remainder test.
// The result sits in an output register; the next candidate is taken once the
// previous result has been written there.
module twin_prime_counter_unit (
  input  logic      clk,
  input  logic      rst,
  tpc_in_if.sink    items,
  tpc_out_if.source results
);

  tpc_pkg::cmd_t  cmd;
  tpc_pkg::stat_t stat;

  tpc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  tpc_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .items   (items),
    .results (results)
  );

endmodule
